@@ rtl/ppt_pkg.sv @@
// Shared types, register map and constants of the proximity presence tracker.
`timescale 1ns / 1ps

package ppt_pkg;

  // Field widths fixed by the interface.
  localparam int DIST_W      = 14;
  localparam int SHOWN_W     = 13;
  localparam int THRESH_W    = 13;
  localparam int MS_W        = 16;
  localparam int PDATA_W     = 32;
  localparam int PADDR_W     = 5;
  localparam int REG_IDX_W   = 3;

  // Module parameter defaults.
  localparam int TIME_BITS_DEF      = 32;
  localparam int DIST_FRAC_BITS_DEF = 4;

  // Range limits of a valid sample, in whole centimeters.
  localparam int DIST_MIN_CM = 2;
  localparam int DIST_MAX_CM = 500;

  // Filter weights out of 256.
  localparam logic [7:0] OLD_WEIGHT = 8'd166;
  localparam logic [7:0] NEW_WEIGHT = 8'd90;

  // Item commands.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Register indexes (byte address / 4).
  localparam logic [REG_IDX_W-1:0] REG_ENTER_THRESHOLD     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_EXIT_THRESHOLD      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STALE_LIMIT_MS      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PRESENT_HOLD_MS     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ABSENT_HOLD_MS      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SMILE_HOLD_MS       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SMILE_SHORTEN_MS    = 3'd6;

  // Register reset values.
  localparam logic [THRESH_W-1:0] ENTER_THRESHOLD_RST     = 13'd720;
  localparam logic [THRESH_W-1:0] EXIT_THRESHOLD_RST      = 13'd960;
  localparam logic [MS_W-1:0]     STALE_LIMIT_MS_RST      = 16'd2000;
  localparam logic [MS_W-1:0]     PRESENT_HOLD_MS_RST     = 16'd0;
  localparam logic [MS_W-1:0]     ABSENT_HOLD_MS_RST      = 16'd0;
  localparam logic [MS_W-1:0]     SMILE_HOLD_MS_RST       = 16'd5000;
  localparam logic [MS_W-1:0]     SMILE_SHORTEN_MS_RST    = 16'd3000;

  typedef struct packed {
    logic [THRESH_W-1:0] enter_threshold;
    logic [THRESH_W-1:0] exit_threshold;
    logic [MS_W-1:0]     stale_limit_ms;
    logic [MS_W-1:0]     present_hold_ms;
    logic [MS_W-1:0]     absent_hold_ms;
    logic [MS_W-1:0]     smile_hold_ms;
    logic [MS_W-1:0]     smile_shorten_ms;
  } cfg_t;

  typedef struct packed {
    logic               presence;
    logic               presence_rose;
    logic [SHOWN_W-1:0] shown_distance;
    logic               distance_fresh;
    logic               smile_active;
  } res_t;

endpackage

@@ rtl/ppt_regs.sv @@
// Configuration register file of the proximity presence tracker, APB-style port.
`timescale 1ns / 1ps

module ppt_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppt_pkg::PADDR_W-1:0]  paddr,
  input  logic [ppt_pkg::PDATA_W-1:0]  pwdata,
  output logic [ppt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output ppt_pkg::cfg_t                cfg_o
);

  ppt_pkg::cfg_t                       cfg_q;
  logic [ppt_pkg::REG_IDX_W-1:0]       idx;
  logic                                wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ppt_pkg::PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enter_threshold     <= ppt_pkg::ENTER_THRESHOLD_RST;
      cfg_q.exit_threshold      <= ppt_pkg::EXIT_THRESHOLD_RST;
      cfg_q.stale_limit_ms      <= ppt_pkg::STALE_LIMIT_MS_RST;
      cfg_q.present_hold_ms     <= ppt_pkg::PRESENT_HOLD_MS_RST;
      cfg_q.absent_hold_ms      <= ppt_pkg::ABSENT_HOLD_MS_RST;
      cfg_q.smile_hold_ms       <= ppt_pkg::SMILE_HOLD_MS_RST;
      cfg_q.smile_shorten_ms    <= ppt_pkg::SMILE_SHORTEN_MS_RST;
    end else if (wr_en) begin
      unique case (idx)
        ppt_pkg::REG_ENTER_THRESHOLD:
          cfg_q.enter_threshold <= pwdata[ppt_pkg::THRESH_W-1:0];
        ppt_pkg::REG_EXIT_THRESHOLD:
          cfg_q.exit_threshold <= pwdata[ppt_pkg::THRESH_W-1:0];
        ppt_pkg::REG_STALE_LIMIT_MS:
          cfg_q.stale_limit_ms <= pwdata[ppt_pkg::MS_W-1:0];
        ppt_pkg::REG_PRESENT_HOLD_MS:
          cfg_q.present_hold_ms <= pwdata[ppt_pkg::MS_W-1:0];
        ppt_pkg::REG_ABSENT_HOLD_MS:
          cfg_q.absent_hold_ms <= pwdata[ppt_pkg::MS_W-1:0];
        ppt_pkg::REG_SMILE_HOLD_MS:
          cfg_q.smile_hold_ms <= pwdata[ppt_pkg::MS_W-1:0];
        ppt_pkg::REG_SMILE_SHORTEN_MS:
          cfg_q.smile_shorten_ms <= pwdata[ppt_pkg::MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ppt_pkg::REG_ENTER_THRESHOLD:
        prdata = ppt_pkg::PDATA_W'(cfg_q.enter_threshold);
      ppt_pkg::REG_EXIT_THRESHOLD:
        prdata = ppt_pkg::PDATA_W'(cfg_q.exit_threshold);
      ppt_pkg::REG_STALE_LIMIT_MS:
        prdata = ppt_pkg::PDATA_W'(cfg_q.stale_limit_ms);
      ppt_pkg::REG_PRESENT_HOLD_MS:
        prdata = ppt_pkg::PDATA_W'(cfg_q.present_hold_ms);
      ppt_pkg::REG_ABSENT_HOLD_MS:
        prdata = ppt_pkg::PDATA_W'(cfg_q.absent_hold_ms);
      ppt_pkg::REG_SMILE_HOLD_MS:
        prdata = ppt_pkg::PDATA_W'(cfg_q.smile_hold_ms);
      ppt_pkg::REG_SMILE_SHORTEN_MS:
        prdata = ppt_pkg::PDATA_W'(cfg_q.smile_shorten_ms);
      default:
        prdata = '0;
    endcase
  end

endmodule

@@ rtl/ppt_core.sv @@
// Tracker state and its combinational update: filter, hysteresis, confirmation, smile timer.
`timescale 1ns / 1ps

module ppt_core #(
  parameter int TIME_BITS      = ppt_pkg::TIME_BITS_DEF,
  parameter int DIST_FRAC_BITS = ppt_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ppt_pkg::cfg_t               cfg_i,
  input  logic                        step_i,
  input  logic                        command_i,
  input  logic [TIME_BITS-1:0]        now_ms_i,
  input  logic                        measure_ok_i,
  input  logic [ppt_pkg::DIST_W-1:0]  measured_distance_i,
  output ppt_pkg::res_t               res_o
);

  localparam logic [31:0] DistMin = 32'(ppt_pkg::DIST_MIN_CM << DIST_FRAC_BITS);
  localparam logic [31:0] DistMax = 32'(ppt_pkg::DIST_MAX_CM << DIST_FRAC_BITS);
  localparam int MixW = ppt_pkg::DIST_W + 9;

  logic [ppt_pkg::DIST_W-1:0] filt_q, filt_d;
  logic                       have_q, have_d;
  logic [TIME_BITS-1:0]       last_q, last_d;
  logic                       cand_q, cand_d;
  logic [TIME_BITS-1:0]       since_q, since_d;
  logic                       pres_q, pres_d;
  logic [TIME_BITS-1:0]       smile_q, smile_d;

  logic                       is_sample;
  logic                       dist_ok;
  logic [TIME_BITS-1:0]       age;
  logic                       fresh_old;
  logic                       detected;
  logic                       cand_chg;
  logic [TIME_BITS-1:0]       elapsed;
  logic [ppt_pkg::MS_W-1:0]   confirm;
  logic                       flip;
  logic                       gain;
  logic                       cut;
  logic [TIME_BITS-1:0]       smile_left;
  logic                       smile_old;
  logic [TIME_BITS-1:0]       hold_ext;
  logic [TIME_BITS-1:0]       shorten_ext;
  logic [MixW-1:0]            mix;
  logic                       fresh_new;
  logic                       smile_new;

  assign is_sample = (command_i == ppt_pkg::CMD_SAMPLE);
  assign dist_ok   = measure_ok_i && (32'(measured_distance_i) >= DistMin)
                     && (32'(measured_distance_i) <= DistMax);

  assign age       = now_ms_i - last_q;
  assign fresh_old = have_q && (age <= TIME_BITS'(cfg_i.stale_limit_ms));

  always_comb begin
    if (dist_ok) begin
      detected = pres_q ? (measured_distance_i <= ppt_pkg::DIST_W'(cfg_i.exit_threshold))
                        : (measured_distance_i <= ppt_pkg::DIST_W'(cfg_i.enter_threshold));
    end else if (!fresh_old) begin
      detected = 1'b0;
    end else begin
      detected = pres_q;
    end
  end

  // A new candidate starts its hold time at this sample, so it has zero elapsed time.
  assign cand_chg = is_sample && (detected != cand_q);
  assign cand_d   = cand_chg ? detected : cand_q;
  assign since_d  = cand_chg ? now_ms_i : since_q;
  assign elapsed  = cand_chg ? '0 : (now_ms_i - since_q);
  assign confirm  = cand_d ? cfg_i.present_hold_ms : cfg_i.absent_hold_ms;
  assign flip     = is_sample && (pres_q != cand_d) && (elapsed >= TIME_BITS'(confirm));
  assign gain     = flip && cand_d;

  assign smile_left  = smile_q - now_ms_i;
  assign smile_old   = (smile_left != '0) && !smile_left[TIME_BITS-1];
  assign cut         = flip && !cand_d && smile_old;
  assign hold_ext    = TIME_BITS'(cfg_i.smile_hold_ms);
  assign shorten_ext = TIME_BITS'(cfg_i.smile_shorten_ms);

  assign pres_d = flip ? cand_d : pres_q;

  // A freshly set deadline lies exactly hold (or shorten) milliseconds ahead.
  always_comb begin
    if (gain) begin
      smile_d   = now_ms_i + hold_ext;
      smile_new = (hold_ext != '0) && !hold_ext[TIME_BITS-1];
    end else if (cut) begin
      smile_d   = now_ms_i + shorten_ext;
      smile_new = (shorten_ext != '0) && !shorten_ext[TIME_BITS-1];
    end else begin
      smile_d   = smile_q;
      smile_new = smile_old;
    end
  end

  assign mix = MixW'(filt_q) * MixW'(ppt_pkg::OLD_WEIGHT)
             + MixW'(measured_distance_i) * MixW'(ppt_pkg::NEW_WEIGHT);

  always_comb begin
    filt_d = filt_q;
    have_d = have_q;
    last_d = last_q;
    if (is_sample && dist_ok) begin
      filt_d = have_q ? mix[ppt_pkg::DIST_W+7:8] : measured_distance_i;
      have_d = 1'b1;
      last_d = now_ms_i;
    end
  end

  assign fresh_new = (is_sample && dist_ok) || fresh_old;

  always_comb begin
    res_o.presence       = pres_d;
    res_o.presence_rose  = gain;
    res_o.shown_distance = fresh_new ? filt_d[ppt_pkg::SHOWN_W-1:0] : '0;
    res_o.distance_fresh = fresh_new;
    res_o.smile_active   = smile_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q  <= '0;
      have_q  <= 1'b0;
      last_q  <= '0;
      cand_q  <= 1'b0;
      since_q <= '0;
      pres_q  <= 1'b0;
      smile_q <= '0;
    end else if (step_i) begin
      filt_q  <= filt_d;
      have_q  <= have_d;
      last_q  <= last_d;
      cand_q  <= cand_d;
      since_q <= since_d;
      pres_q  <= pres_d;
      smile_q <= smile_d;
    end
  end

endmodule

@@ rtl/proximity_presence_tracker.sv @@
// Top level of the proximity presence tracker: input register, tracker core, result register.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid_i / in_stall_o) carries one word per range sample or frame
// query: command_i, now_ms_i, measure_ok_i and measured_distance_i. A word is taken at a
// rising edge where in_valid_i is high and in_stall_o is low. Every word produces exactly
// one result word on the output channel (out_valid_o / out_stall_i): presence, the rise
// pulse, the shown distance, its freshness and the smile flag.
// A word accepted into the input register advances once the result register is free: at
// that edge the tracker state is updated and the result is loaded into the result register,
// which then offers it. Throughput is one word per cycle while the receiver does not stall:
// the whole update (filter multiply-add, threshold compares, time differences) is one
// pass of logic between the input register and the result register, and the state
// feedback closes within that same cycle.
// When the receiver stalls, the result register holds its word and the input register
// holds the next one; only then is in_stall_o raised, so at most two words are in flight.
// Reset clears both registers' valid flags and all tracker state, and loads the
// configuration registers with their defaults. Configuration is written through the
// APB-style port by the user only while no word is in flight; the block does not enforce it.

module proximity_presence_tracker #(
  parameter int TIME_BITS      = ppt_pkg::TIME_BITS_DEF,
  parameter int DIST_FRAC_BITS = ppt_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppt_pkg::PADDR_W-1:0]   paddr,
  input  logic [ppt_pkg::PDATA_W-1:0]   pwdata,
  output logic [ppt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [TIME_BITS-1:0]          now_ms_i,
  input  logic                          measure_ok_i,
  input  logic [ppt_pkg::DIST_W-1:0]    measured_distance_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          presence_o,
  output logic                          presence_rose_o,
  output logic [ppt_pkg::SHOWN_W-1:0]   shown_distance_o,
  output logic                          distance_fresh_o,
  output logic                          smile_active_o
);

  ppt_pkg::cfg_t               cfg;
  ppt_pkg::res_t               res;
  ppt_pkg::res_t               res_q;

  // Input register.
  logic                        in_valid_q, in_valid_d;
  logic                        cmd_q;
  logic [TIME_BITS-1:0]        now_q;
  logic                        ok_q;
  logic [ppt_pkg::DIST_W-1:0]  dist_q;

  logic                        out_valid_q, out_valid_d;
  logic                        out_free;
  logic                        step;
  logic                        in_take;

  ppt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppt_core #(
    .TIME_BITS      (TIME_BITS),
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .step_i              (step),
    .command_i           (cmd_q),
    .now_ms_i            (now_q),
    .measure_ok_i        (ok_q),
    .measured_distance_i (dist_q),
    .res_o               (res)
  );

  // The result register can take a new word when it is empty or being drained now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take ? 1'b1 : (step ? 1'b0 : in_valid_q);
  assign out_valid_d = step ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= command_i;
      now_q  <= now_ms_i;
      ok_q   <= measure_ok_i;
      dist_q <= measured_distance_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign presence_o       = res_q.presence;
  assign presence_rose_o  = res_q.presence_rose;
  assign shown_distance_o = res_q.shown_distance;
  assign distance_fresh_o = res_q.distance_fresh;
  assign smile_active_o   = res_q.smile_active;

  // The input side is only held back while a word waits in the input register.
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with an empty input register");

  // An accepted word is always held in the input register at the next edge.
  a_take_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted word lost from the input register");

  // A rise pulse always comes with presence set.
  a_rose_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && presence_rose_o) |-> presence_o)
    else $error("presence rise reported without presence");

  // A stale or missing distance is shown as zero.
  a_stale_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !distance_fresh_o) |-> (shown_distance_o == '0))
    else $error("distance shown while not fresh");

  // A word that advances while the result register is stalled would overwrite a result.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !step)
    else $error("result overwritten while stalled");

endmodule

@@ dv/proximity_presence_tracker_tb.sv @@
// Self-checking testbench of the proximity presence tracker: stimulus, status prediction, checks.
`timescale 1ns / 1ps

module proximity_presence_tracker_tb;
  import ppt_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  // Cycles without any word moving on either channel before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  // Index one past the register list; writes there must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;
  // Valid sample range in 1/16 cm.
  localparam int DIST_LO = DIST_MIN_CM << DIST_FRAC_BITS_DEF;
  localparam int DIST_HI = DIST_MAX_CM << DIST_FRAC_BITS_DEF;
  localparam int TB = TIME_BITS_DEF;

  // One word of the input channel.
  typedef struct packed {
    logic                cmd;
    logic [TB-1:0]       now;
    logic                ok;
    logic [DIST_W-1:0]   dist_val;
  } range_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                command_i = CMD_SAMPLE;
  logic [TB-1:0]       now_ms_i = '0;
  logic                measure_ok_i = 1'b0;
  logic [DIST_W-1:0]   measured_distance_i = '0;

  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                presence_o;
  logic                presence_rose_o;
  logic [SHOWN_W-1:0]  shown_distance_o;
  logic                distance_fresh_o;
  logic                smile_active_o;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  proximity_presence_tracker dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .now_ms_i           (now_ms_i),
    .measure_ok_i       (measure_ok_i),
    .measured_distance_i(measured_distance_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .presence_o         (presence_o),
    .presence_rose_o    (presence_rose_o),
    .shown_distance_o   (shown_distance_o),
    .distance_fresh_o   (distance_fresh_o),
    .smile_active_o     (smile_active_o)
  );

  // ---------------------------------------------------------------------------
  // Tracker state mirrored by the testbench. The configuration copy is changed
  // only while the block is idle, together with the register write itself.
  // ---------------------------------------------------------------------------
  cfg_t               trk_cfg;
  logic [DIST_W-1:0]  trk_filt = '0;
  logic               trk_have = 1'b0;
  logic [TB-1:0]      trk_last_valid = '0;
  logic               trk_cand = 1'b0;
  logic [TB-1:0]      trk_cand_since = '0;
  logic               trk_present = 1'b0;
  logic [TB-1:0]      trk_smile_end = '0;

  range_word_t word_q[$];     // words waiting to be driven
  res_t        status_due_q[$];  // status words the block still owes, oldest first
  int          n_pushed = 0;  // words handed to the driver so far
  int          n_matched = 0; // status words that met an expectation
  int          n_errors = 0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  logic        in_taken = 1'b0;
  int          quiet_cycles = 0;
  range_word_t drv_word;
  res_t        seen_status;
  res_t        due_status;
  logic [TB-1:0] now_cursor = '0;
  int          walk_dist = 400;

  // The distance is fresh while one exists and its age does not pass the stale limit.
  // Ages wrap with the time counter, so a time that runs backward looks very old.
  function automatic logic dist_fresh(input logic [TB-1:0] now);
    logic [TB-1:0] age;
    age = now - trk_last_valid;
    return trk_have && (age <= TB'(trk_cfg.stale_limit_ms));
  endfunction

  // The smile runs while its deadline lies strictly ahead, read as a signed difference.
  function automatic logic smile_on(input logic [TB-1:0] now);
    logic [TB-1:0] left;
    left = trk_smile_end - now;
    return (left != '0) && !left[TB-1];
  endfunction

  // Advances the mirrored tracker by one word and returns the status it must report.
  function automatic res_t next_status(input logic cmd, input logic [TB-1:0] now,
                                       input logic ok, input logic [DIST_W-1:0] d);
    res_t          r;
    logic          detected;
    logic          rose;
    logic          fresh;
    logic [21:0]   acc;
    logic [TB-1:0] held;
    logic [MS_W-1:0] confirm;
    rose = 1'b0;
    if (cmd == CMD_SAMPLE) begin
      detected = trk_present;
      if (ok && int'(d) >= DIST_LO && int'(d) <= DIST_HI) begin
        // The first valid sample loads the filter; later ones are blended in, truncating.
        if (!trk_have) begin
          trk_filt = d;
        end else begin
          acc = 22'(trk_filt) * 22'(OLD_WEIGHT) + 22'(d) * 22'(NEW_WEIGHT);
          trk_filt = acc[21:8];
        end
        trk_have = 1'b1;
        trk_last_valid = now;
        // Hysteresis: a present target is kept up to the exit threshold.
        detected = trk_present ? (d <= DIST_W'(trk_cfg.exit_threshold))
                               : (d <= DIST_W'(trk_cfg.enter_threshold));
      end else if (!dist_fresh(now)) begin
        detected = 1'b0;
      end
      if (detected != trk_cand) begin
        trk_cand = detected;
        trk_cand_since = now;
      end
      confirm = trk_cand ? trk_cfg.present_hold_ms : trk_cfg.absent_hold_ms;
      held = now - trk_cand_since;
      if (trk_present != trk_cand && held >= TB'(confirm)) begin
        trk_present = trk_cand;
        if (trk_present) begin
          trk_smile_end = now + TB'(trk_cfg.smile_hold_ms);
          rose = 1'b1;
        end else if (smile_on(now)) begin
          // Losing presence cuts a running smile short; an expired one stays expired.
          trk_smile_end = now + TB'(trk_cfg.smile_shorten_ms);
        end
      end
    end
    fresh = dist_fresh(now);
    r.presence       = trk_present;
    r.presence_rose  = rose;
    r.shown_distance = fresh ? trk_filt[SHOWN_W-1:0] : '0;
    r.distance_fresh = fresh;
    r.smile_active   = smile_on(now);
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver. Inputs change at the falling edge only. A word stays on the bus,
  // unchanged, until the rising edge that accepts it; only then may the sender
  // move on to the next word or go idle.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < snk_idle_pct);
      if (!in_valid_i || in_taken) begin
        if (word_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          drv_word = word_q.pop_front();
          command_i           <= drv_word.cmd;
          now_ms_i            <= drv_word.now;
          measure_ok_i        <= drv_word.ok;
          measured_distance_i <= drv_word.dist_val;
          in_valid_i          <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each rising edge the outgoing status word, if accepted, is
  // checked first against the oldest expectation; then an accepted input word
  // is run through the mirrored tracker. Checking before predicting keeps a
  // stray status word from matching the prediction made in the same cycle.
  // The watchdog lives here too, since it counts edges where nothing moved.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        seen_status.presence       = presence_o;
        seen_status.presence_rose  = presence_rose_o;
        seen_status.shown_distance = shown_distance_o;
        seen_status.distance_fresh = distance_fresh_o;
        seen_status.smile_active   = smile_active_o;
        if (status_due_q.size() == 0) begin
          report("status word with none expected", 32'(seen_status), '0);
        end else begin
          due_status = status_due_q.pop_front();
          if (seen_status.presence !== due_status.presence)
            report("presence", 32'(seen_status.presence), 32'(due_status.presence));
          if (seen_status.presence_rose !== due_status.presence_rose)
            report("presence_rose", 32'(seen_status.presence_rose),
                   32'(due_status.presence_rose));
          if (seen_status.shown_distance !== due_status.shown_distance)
            report("shown_distance", 32'(seen_status.shown_distance),
                   32'(due_status.shown_distance));
          if (seen_status.distance_fresh !== due_status.distance_fresh)
            report("distance_fresh", 32'(seen_status.distance_fresh),
                   32'(due_status.distance_fresh));
          if (seen_status.smile_active !== due_status.smile_active)
            report("smile_active", 32'(seen_status.smile_active),
                   32'(due_status.smile_active));
          n_matched++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        status_due_q.push_back(next_status(command_i, now_ms_i, measure_ok_i,
                                           measured_distance_i));
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
          $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic add_word(input logic cmd, input logic [TB-1:0] now, input logic ok,
                          input logic [DIST_W-1:0] d);
    range_word_t w;
    w.cmd      = cmd;
    w.now      = now;
    w.ok       = ok;
    w.dist_val = d;
    word_q.push_back(w);
    n_pushed++;
  endtask

  // Returns once every queued word has been taken and answered. Called and
  // returning at a falling edge, so register writes may start right away.
  task automatic wait_drained();
    while (n_matched != n_pushed) @(negedge clk_i);
  endtask

  // One APB write: a setup cycle, then an access cycle; pready is always high,
  // so the register takes the value at the rising edge inside the access cycle.
  // With junk set, the bits above the register's width carry random noise that
  // the block must drop.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value,
                           input bit junk);
    logic [31:0] data;
    logic [31:0] keep;
    keep = (idx == REG_ENTER_THRESHOLD || idx == REG_EXIT_THRESHOLD) ? 32'h1FFF : 32'hFFFF;
    data = junk ? ((value & keep) | ($urandom & ~keep)) : value;
    case (idx)
      REG_ENTER_THRESHOLD:     trk_cfg.enter_threshold     = data[THRESH_W-1:0];
      REG_EXIT_THRESHOLD:      trk_cfg.exit_threshold      = data[THRESH_W-1:0];
      REG_STALE_LIMIT_MS:      trk_cfg.stale_limit_ms      = data[MS_W-1:0];
      REG_PRESENT_HOLD_MS:     trk_cfg.present_hold_ms     = data[MS_W-1:0];
      REG_ABSENT_HOLD_MS:      trk_cfg.absent_hold_ms      = data[MS_W-1:0];
      REG_SMILE_HOLD_MS:       trk_cfg.smile_hold_ms       = data[MS_W-1:0];
      REG_SMILE_SHORTEN_MS:    trk_cfg.smile_shorten_ms    = data[MS_W-1:0];
      default: ;  // Past the end of the register map: the block ignores the write.
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic cfg_t make_cfg(input int unsigned enter_th, input int unsigned exit_th,
                                    input int unsigned stale, input int unsigned p_conf,
                                    input int unsigned a_conf, input int unsigned hold,
                                    input int unsigned shorten);
    cfg_t c;
    c.enter_threshold     = enter_th[THRESH_W-1:0];
    c.exit_threshold      = exit_th[THRESH_W-1:0];
    c.stale_limit_ms      = stale[MS_W-1:0];
    c.present_hold_ms     = p_conf[MS_W-1:0];
    c.absent_hold_ms      = a_conf[MS_W-1:0];
    c.smile_hold_ms       = hold[MS_W-1:0];
    c.smile_shorten_ms    = shorten[MS_W-1:0];
    return c;
  endfunction

  task automatic apply_cfg(input cfg_t c, input bit junk);
    write_reg(REG_ENTER_THRESHOLD, 32'(c.enter_threshold), junk);
    write_reg(REG_EXIT_THRESHOLD, 32'(c.exit_threshold), junk);
    write_reg(REG_STALE_LIMIT_MS, 32'(c.stale_limit_ms), junk);
    write_reg(REG_PRESENT_HOLD_MS, 32'(c.present_hold_ms), junk);
    write_reg(REG_ABSENT_HOLD_MS, 32'(c.absent_hold_ms), junk);
    write_reg(REG_SMILE_HOLD_MS, 32'(c.smile_hold_ms), junk);
    write_reg(REG_SMILE_SHORTEN_MS, 32'(c.smile_shorten_ms), junk);
  endtask

  // Random words that look like a real sensor: time mostly moves in steps of about
  // 100 ms with the odd long silence or wild jump, and the distance follows a
  // random walk so that presence holds long enough for the confirm times and the
  // smile timer to matter. Some samples sit right at a threshold, some fall
  // outside the valid range, some report a failed echo, and some words are
  // frame queries carrying random junk in the ignored fields.
  task automatic add_random_words(input int count);
    int          sel;
    logic [TB-1:0] step;
    logic        ok;
    logic [DIST_W-1:0] d;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 3) step = $urandom;
      else if (sel < 10) step = $urandom_range(70000, 1500);
      else if (sel < 14) step = '0;
      else step = $urandom_range(250, 20);
      now_cursor = now_cursor + step;
      if ($urandom_range(99) < 20) begin
        add_word(CMD_QUERY, now_cursor, 1'($urandom_range(1)), DIST_W'($urandom_range(16383)));
      end else begin
        sel = $urandom_range(99);
        if (sel < 8) begin
          walk_dist = $urandom_range(DIST_HI, DIST_LO);
        end else if (sel < 16) begin
          walk_dist = (sel < 12 ? int'(trk_cfg.enter_threshold) : int'(trk_cfg.exit_threshold))
                      + int'($urandom_range(6)) - 3;
        end else begin
          walk_dist = walk_dist + int'($urandom_range(400)) - 200;
        end
        if (walk_dist < 20) walk_dist = 20;
        if (walk_dist > DIST_HI + 50) walk_dist = DIST_HI + 50;
        d = DIST_W'(walk_dist);
        sel = $urandom_range(99);
        if (sel < 4) d = DIST_W'($urandom_range(DIST_LO - 1));
        else if (sel < 8) d = DIST_W'($urandom_range(16383, DIST_HI + 1));
        ok = ($urandom_range(99) >= 8);
        add_word(CMD_SAMPLE, now_cursor, ok, d);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t plan[6];
    trk_cfg = make_cfg(ENTER_THRESHOLD_RST, EXIT_THRESHOLD_RST, STALE_LIMIT_MS_RST,
                       PRESENT_HOLD_MS_RST, ABSENT_HOLD_MS_RST,
                       SMILE_HOLD_MS_RST, SMILE_SHORTEN_MS_RST);
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // The first stretch idles the sender lightly and stalls the receiver often.
    src_idle_pct = 18;
    snk_idle_pct = 71;

    // Directed words against the reset configuration.
    add_word(CMD_QUERY, 100, 1'b1, 16383);     // Query before anything is known.
    add_word(CMD_SAMPLE, 200, 1'b0, 100);      // Failed echo with no distance yet.
    add_word(CMD_SAMPLE, 300, 1'b1, 31);       // Just short of 2 cm, so invalid.
    add_word(CMD_SAMPLE, 400, 1'b1, 32);       // Exactly 2 cm loads the filter, present.
    add_word(CMD_SAMPLE, 500, 1'b1, 8000);     // Exactly 500 cm: lost, smile cut short.
    add_word(CMD_SAMPLE, 600, 1'b1, 8001);     // Just past 500 cm, with a fresh distance.
    add_word(CMD_SAMPLE, 700, 1'b1, 720);      // On the enter threshold.
    add_word(CMD_SAMPLE, 800, 1'b1, 960);      // On the exit threshold, so kept.
    add_word(CMD_SAMPLE, 900, 1'b1, 961);      // One step past exit, so lost.
    add_word(CMD_SAMPLE, 1000, 1'b1, 721);     // One step past enter, not regained.
    add_word(CMD_SAMPLE, 1100, 1'b1, 0);       // Zero distance is invalid.
    add_word(CMD_SAMPLE, 1200, 1'b0, 16383);   // Largest field with a failed echo.
    add_word(CMD_QUERY, 3000, 1'b0, 0);        // Age equals the stale limit: still fresh.
    add_word(CMD_QUERY, 3001, 1'b1, 5000);     // One ms later it is stale.
    add_word(CMD_SAMPLE, 3002, 1'b0, 200);     // Invalid sample over a stale distance.
    add_word(CMD_SAMPLE, 32'hFFFF_FF00, 1'b1, 100);  // Smile deadline wraps past zero.
    add_word(CMD_QUERY, 32'h0000_0100, 1'b1, 0);     // Age measured across the wrap.
    add_word(CMD_QUERY, 32'hFFFF_FFFF, 1'b0, 0);     // Back before the wrap: still fresh.
    add_word(CMD_SAMPLE, 9000, 1'b0, 0);       // Failed echo over a stale distance: lost.
    wait_drained();

    // Confirm times: a candidate must hold for the full time before presence moves.
    apply_cfg(make_cfg(720, 960, 2000, 300, 300, 5000, 3000), 1'b0);
    write_reg(REG_NONE, $urandom, 1'b0);
    add_word(CMD_SAMPLE, 10000, 1'b1, 100);
    add_word(CMD_SAMPLE, 10100, 1'b1, 100);    // Held 100 ms, not yet confirmed.
    add_word(CMD_SAMPLE, 10300, 1'b1, 100);    // Held exactly 300 ms: presence rises.
    add_word(CMD_SAMPLE, 10400, 1'b1, 5000);
    add_word(CMD_SAMPLE, 10699, 1'b1, 5000);   // One ms short of the absence time.
    add_word(CMD_SAMPLE, 10700, 1'b1, 5000);   // Absence confirmed.
    wait_drained();

    // Random stretches, each under its own register setting. Every stretch ends
    // with the sender holding off until every status word has come back.
    plan[0] = make_cfg(720, 960, 2000, 200, 400, 5000, 3000);
    plan[1] = make_cfg(0, 0, 0, 0, 0, 0, 0);
    plan[2] = make_cfg(8000, 8000, 65535, 65535, 65535, 65535, 65535);
    plan[3] = make_cfg($urandom_range(8000), $urandom_range(8000), $urandom_range(65535),
                       $urandom_range(1500), $urandom_range(1500), $urandom_range(65535),
                       $urandom_range(65535));
    plan[4] = make_cfg(2000, 500, 300, 100, 100, 1000, 400);
    plan[5] = make_cfg($urandom_range(8000), $urandom_range(8000), $urandom_range(65535),
                       $urandom_range(1500), $urandom_range(1500), $urandom_range(65535),
                       $urandom_range(65535));
    now_cursor = 20000;
    for (int b = 0; b < 6; b++) begin
      if (b == 2) begin
        src_idle_pct = 71;
        snk_idle_pct = 18;
      end else if (b == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      // One stretch starts just short of the time wrap.
      if (b == 3) now_cursor = 32'hFFFF_0000;
      apply_cfg(plan[b], b == 5);
      add_random_words(330);
      wait_drained();
    end

    // Let any stray status word show up before the final check.
    repeat (8) @(posedge clk_i);
    if (status_due_q.size() != 0) begin
      report("status words never delivered", '0, 32'(status_due_q.size()));
    end
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
